// File: rtl/cpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpid_pkg: shared types and microprogram for the cascaded pid controller
// Register map, control word layout and the per-loop program table.
// ----------------------------------------------------------------------------
package cpid_pkg;

	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int ACCUM_WIDTH_DEF    = 32;
	localparam int GAIN_FRAC_BITS_DEF = 8;

	localparam int LOOPS     = 3;
	localparam int LOOP_W    = 2;
	localparam int GAIN_W    = 16;
	localparam int CFG_W     = 48;
	localparam int LIMIT_W   = 31;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W    = 3;

	localparam logic [LOOP_W-1:0] LAST_LOOP = LOOP_W'(LOOPS - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_GAINS = 3'd0,
		REG_SPD_GAINS = 3'd1,
		REG_CUR_GAINS = 3'd2,
		REG_POS_LIMIT = 3'd3,
		REG_SPD_LIMIT = 3'd4,
		REG_CUR_LIMIT = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		MUL_NONE = 2'd0,
		MUL_KI   = 2'd1,
		MUL_KP   = 2'd2,
		MUL_KD   = 2'd3
	} mul_op_t;

	typedef enum logic [2:0] {
		ALU_NOP      = 3'd0,
		ALU_ERR      = 3'd1,
		ALU_DIFF     = 3'd2,
		ALU_ISAT     = 3'd3,
		ALU_LIMIT    = 3'd4,
		ALU_ACC_PROD = 3'd5,
		ALU_ACC_INT  = 3'd6,
		ALU_ROUND    = 3'd7
	} alu_op_t;

	typedef enum logic {
		JMP_NONE = 1'b0,
		JMP_LOOP = 1'b1
	} jump_t;

	typedef struct packed {
		alu_op_t alu;
		mul_op_t mul;
		jump_t   jmp;
	} ucode_t;

	typedef struct packed {
		logic              exec;
		logic [LOOP_W-1:0] loop;
		ucode_t            uc;
	} seq_ctrl_t;

	// one loop of the cascade; the last word jumps to the next loop
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		begin
			case (step)
				3'd0:    w = '{alu: ALU_ERR,      mul: MUL_NONE, jmp: JMP_NONE};
				3'd1:    w = '{alu: ALU_DIFF,     mul: MUL_KI,   jmp: JMP_NONE};
				3'd2:    w = '{alu: ALU_ISAT,     mul: MUL_KP,   jmp: JMP_NONE};
				3'd3:    w = '{alu: ALU_LIMIT,    mul: MUL_KD,   jmp: JMP_NONE};
				3'd4:    w = '{alu: ALU_ACC_PROD, mul: MUL_NONE, jmp: JMP_NONE};
				3'd5:    w = '{alu: ALU_ACC_INT,  mul: MUL_NONE, jmp: JMP_NONE};
				3'd6:    w = '{alu: ALU_ROUND,    mul: MUL_NONE, jmp: JMP_NONE};
				default: w = '{alu: ALU_NOP,      mul: MUL_NONE, jmp: JMP_LOOP};
			endcase
			return w;
		end
	endfunction

endpackage
`default_nettype wire

// File: rtl/cascaded_pid_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cascaded_pid_controller: position, speed and current pid loops in cascade
// Each loop's saturated output is the setpoint of the next loop.
// ----------------------------------------------------------------------------
//  channel  | signals                              | direction | transfer when
//  ---------+--------------------------------------+-----------+---------------
//  input    | in_valid/in_ready + four samples     | in        | valid & ready
//  output   | out_valid/out_ready + three commands | out       | valid & ready
//  config   | cfg_write, cfg_index, cfg_data       | in        | cfg_write
//
// each sample runs 3 loops x 8 microcode steps on one shared multiplier and
// accumulator; in_ready stays low while the sequencer is busy, so a new sample
// is taken only after the previous one has finished.
// reset loads gains with zero, integral limits with all ones, clears loop state.
// a waiting result sits in the output register; the sequencer holds on its
// final step only if that register is full and not being read.
// ----------------------------------------------------------------------------
module cascaded_pid_controller #(
	parameter int SAMPLE_WIDTH   = cpid_pkg::SAMPLE_WIDTH_DEF,
	parameter int ACCUM_WIDTH    = cpid_pkg::ACCUM_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = cpid_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_write,
	input  wire logic [cpid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cpid_pkg::CFG_W-1:0]      cfg_data,
	// input samples
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  target_position,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  measured_position,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  measured_speed,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  measured_current,
	// results
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]       speed_command,
	output logic signed [SAMPLE_WIDTH-1:0]       current_command,
	output logic signed [SAMPLE_WIDTH-1:0]       drive_output
);
	import cpid_pkg::*;

	// configuration registers
	logic [LOOPS-1:0][CFG_W-1:0]   gains_q;
	logic [LOOPS-1:0][LIMIT_W-1:0] limits_q;
	logic [LOOPS-1:0]              clear;

	// captured sample
	logic signed [SAMPLE_WIDTH-1:0] tp_q, mp_q, ms_q, mc_q;

	// output register
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] spd_q, cur_q, drv_q;

	seq_ctrl_t                      ctrl;
	logic                           done;
	logic                           in_xfer;
	logic                           out_free;
	logic signed [SAMPLE_WIDTH-1:0] dp_spd, dp_cur, dp_drv;

	assign in_ready = !ctrl.exec;
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// a write to any of a loop's registers clears that loop's state
	always_comb begin
		clear = '0;
		if (cfg_write) begin
			unique case (cfg_index) inside
				REG_POS_GAINS, REG_POS_LIMIT: clear[0] = 1'b1;
				REG_SPD_GAINS, REG_SPD_LIMIT: clear[1] = 1'b1;
				REG_CUR_GAINS, REG_CUR_LIMIT: clear[2] = 1'b1;
				default:                      clear    = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q  <= '0;
			limits_q <= '1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_POS_GAINS: gains_q[0]  <= cfg_data;
				REG_SPD_GAINS: gains_q[1]  <= cfg_data;
				REG_CUR_GAINS: gains_q[2]  <= cfg_data;
				REG_POS_LIMIT: limits_q[0] <= cfg_data[LIMIT_W-1:0];
				REG_SPD_LIMIT: limits_q[1] <= cfg_data[LIMIT_W-1:0];
				REG_CUR_LIMIT: limits_q[2] <= cfg_data[LIMIT_W-1:0];
				default:       ;  // unknown index, write dropped
			endcase
		end
	end

	// sample capture on input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tp_q <= target_position;
			mp_q <= measured_position;
			ms_q <= measured_speed;
			mc_q <= measured_current;
		end
	end

	cpid_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_xfer),
		.out_free (out_free),
		.ctrl     (ctrl),
		.done     (done)
	);

	cpid_dp #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.ACCUM_WIDTH    (ACCUM_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.clear             (clear),
		.target_position   (tp_q),
		.measured_position (mp_q),
		.measured_speed    (ms_q),
		.measured_current  (mc_q),
		.gains             (gains_q),
		.limits            (limits_q),
		.speed_command     (dp_spd),
		.current_command   (dp_cur),
		.drive_output      (dp_drv)
	);

	// output register, loaded when the last loop finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			spd_q <= dp_spd;
			cur_q <= dp_cur;
			drv_q <= dp_drv;
		end
	end

	assign out_valid       = out_valid_q;
	assign speed_command   = spd_q;
	assign current_command = cur_q;
	assign drive_output    = drv_q;

endmodule
`default_nettype wire

// File: rtl/cpid_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpid_seq: microcode sequencer
// Step counter, program table lookup and loop counter with conditional jump.
// ----------------------------------------------------------------------------
module cpid_seq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               out_free,
	output cpid_pkg::seq_ctrl_t     ctrl,
	output logic                    done
);
	import cpid_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [LOOP_W-1:0] loop_q;
	ucode_t            uc;

	assign uc = ucode_rom(step_q);

	assign done = busy_q && (uc.jmp == JMP_LOOP) && (loop_q == LAST_LOOP) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			loop_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
			loop_q <= '0;
		end else if (busy_q) begin
			if (uc.jmp == JMP_LOOP) begin
				if (loop_q != LAST_LOOP) begin
					loop_q <= loop_q + 1'b1;
					step_q <= '0;
				end else if (out_free) begin
					busy_q <= 1'b0;
				end
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign ctrl = '{exec: busy_q, loop: loop_q, uc: uc};

endmodule
`default_nettype wire

// File: rtl/cpid_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpid_dp: shared pid datapath
// One multiplier, accumulator, integral saturation and limit, output rounding.
// ----------------------------------------------------------------------------
module cpid_dp #(
	parameter int SAMPLE_WIDTH   = cpid_pkg::SAMPLE_WIDTH_DEF,
	parameter int ACCUM_WIDTH    = cpid_pkg::ACCUM_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = cpid_pkg::GAIN_FRAC_BITS_DEF
) (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire cpid_pkg::seq_ctrl_t                             ctrl,
	input  wire logic [cpid_pkg::LOOPS-1:0]                      clear,
	input  wire logic signed [SAMPLE_WIDTH-1:0]                  target_position,
	input  wire logic signed [SAMPLE_WIDTH-1:0]                  measured_position,
	input  wire logic signed [SAMPLE_WIDTH-1:0]                  measured_speed,
	input  wire logic signed [SAMPLE_WIDTH-1:0]                  measured_current,
	input  wire logic [cpid_pkg::LOOPS-1:0][cpid_pkg::CFG_W-1:0]   gains,
	input  wire logic [cpid_pkg::LOOPS-1:0][cpid_pkg::LIMIT_W-1:0] limits,
	output logic signed [SAMPLE_WIDTH-1:0]                       speed_command,
	output logic signed [SAMPLE_WIDTH-1:0]                       current_command,
	output logic signed [SAMPLE_WIDTH-1:0]                       drive_output
);
	import cpid_pkg::*;

	localparam int SW  = SAMPLE_WIDTH;
	localparam int AW  = ACCUM_WIDTH;
	localparam int EW  = SW + 1;
	localparam int DW  = SW + 2;
	localparam int PW  = GAIN_W + DW;
	localparam int IW  = ((AW > PW) ? AW : PW) + 1;
	localparam int CW  = (AW > LIMIT_W) ? AW : LIMIT_W;
	localparam int ACW = ((PW > AW) ? PW : AW) + 2;
	localparam int RW  = ACW + 1;

	localparam logic signed [IW-1:0] IMAX = {{(IW-AW+1){1'b0}}, {(AW-1){1'b1}}};
	localparam logic signed [IW-1:0] IMIN = ~IMAX;
	localparam logic signed [RW-1:0] RMAX = {{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}};
	localparam logic signed [RW-1:0] RMIN = ~RMAX;
	localparam logic signed [RW-1:0] HALF = RW'((2 ** GAIN_FRAC_BITS) >> 1);

	logic signed [EW-1:0]  err_q;
	logic signed [DW-1:0]  diff_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [AW-1:0]  isat_q;
	logic signed [ACW-1:0] acc_q;
	logic signed [SW-1:0]  cmd_q   [LOOPS];
	logic signed [EW-1:0]  prev_q  [LOOPS];
	logic signed [AW-1:0]  integ_q [LOOPS];

	logic [LOOP_W-1:0]         k;
	logic [CFG_W-1:0]          gsel;
	logic signed [GAIN_W-1:0]  kp, ki, kd, mgain;
	logic signed [DW-1:0]      mop;
	logic signed [PW-1:0]      prod_n;
	logic signed [SW-1:0]      setp, meas;
	logic signed [EW-1:0]      err_n;
	logic signed [DW-1:0]      diff_n;
	logic signed [IW-1:0]      isum;
	logic signed [AW-1:0]      isat_n;
	logic [AW-1:0]             mag;
	logic                      over;
	logic signed [AW-1:0]      lim_n;
	logic signed [RW-1:0]      rsum, rshift;
	logic signed [SW-1:0]      rnd;

	assign k    = ctrl.loop;
	assign gsel = gains[k];
	assign kp   = gsel[GAIN_W-1:0];
	assign ki   = gsel[2*GAIN_W-1:GAIN_W];
	assign kd   = gsel[3*GAIN_W-1:2*GAIN_W];

	// after the first loop, the setpoint comes from the previous loop's command
	always_comb begin
		case (k)
			2'd0: begin
				setp = target_position;
				meas = measured_position;
			end
			2'd1: begin
				setp = cmd_q[0];
				meas = measured_speed;
			end
			default: begin
				setp = cmd_q[1];
				meas = measured_current;
			end
		endcase
	end

	assign err_n  = EW'(setp) - EW'(meas);
	assign diff_n = DW'(err_q) - DW'(prev_q[k]);

	always_comb begin
		case (ctrl.uc.mul)
			MUL_KI:  mgain = ki;
			MUL_KP:  mgain = kp;
			MUL_KD:  mgain = kd;
			default: mgain = '0;
		endcase
	end

	assign mop    = (ctrl.uc.mul == MUL_KD) ? diff_q : DW'(err_q);
	assign prod_n = PW'(mgain) * PW'(mop);

	// integral update saturated to the accumulator width
	assign isum = IW'(integ_q[k]) + IW'(prod_q);
	always_comb begin
		if (isum > IMAX) begin
			isat_n = IMAX[AW-1:0];
		end else if (isum < IMIN) begin
			isat_n = IMIN[AW-1:0];
		end else begin
			isat_n = isum[AW-1:0];
		end
	end

	assign mag   = isat_q[AW-1] ? (~isat_q + 1'b1) : isat_q;
	assign over  = CW'(mag) > CW'(limits[k]);
	assign lim_n = over ? '0 : isat_q;

	// round half up, then clamp to the sample range
	assign rsum   = RW'(acc_q) + HALF;
	assign rshift = rsum >>> GAIN_FRAC_BITS;
	always_comb begin
		if (rshift > RMAX) begin
			rnd = RMAX[SW-1:0];
		end else if (rshift < RMIN) begin
			rnd = RMIN[SW-1:0];
		end else begin
			rnd = rshift[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOOPS; i++) begin
				prev_q[i]  <= '0;
				integ_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < LOOPS; i++) begin
				if (clear[i]) begin
					prev_q[i]  <= '0;
					integ_q[i] <= '0;
				end else if (ctrl.exec && (k == LOOP_W'(i))) begin
					if (ctrl.uc.alu == ALU_DIFF) begin
						prev_q[i] <= err_q;
					end
					if (ctrl.uc.alu == ALU_LIMIT) begin
						integ_q[i] <= lim_n;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			if (ctrl.uc.mul != MUL_NONE) begin
				prod_q <= prod_n;
			end
			case (ctrl.uc.alu)
				ALU_ERR:      err_q  <= err_n;
				ALU_DIFF:     diff_q <= diff_n;
				ALU_ISAT:     isat_q <= isat_n;
				ALU_LIMIT:    acc_q  <= ACW'(prod_q);
				ALU_ACC_PROD: acc_q  <= acc_q + ACW'(prod_q);
				ALU_ACC_INT:  acc_q  <= acc_q + ACW'(integ_q[k]);
				ALU_ROUND:    cmd_q[k] <= rnd;
				default:      ;
			endcase
		end
	end

	assign speed_command   = cmd_q[0];
	assign current_command = cmd_q[1];
	assign drive_output    = cmd_q[2];

endmodule
`default_nettype wire
